>>> rtl/lpa_pkg.sv
// ----------------------------------------------------------------------------
// lpa_pkg
// Shared constants and types for the LIFO pool allocator: default sizes,
// alignment, request codes and result status codes.
// ----------------------------------------------------------------------------
package lpa_pkg;

   // Default sizing for the top level parameters
   localparam int DEF_MAX_BLOCKS = 64;
   localparam int DEF_ADDR_BITS  = 16;

   // Allocation granule; must be a power of two so rounding is a mask
   localparam int ALIGN_BYTES = 8;

   // Request codes on req_action
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_ORDER     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

>>> rtl/lpa_ram.sv
// ----------------------------------------------------------------------------
// lpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lifo_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// lifo_pool_allocator_unit
// Stack-ordered allocator over a pool of configured size. Allocates hand out
// the current free offset and push the block; frees must name the top block
// and pop it.
// ----------------------------------------------------------------------------
//
//  Port group  Direction  Handshake           Carries
//  ----------  ---------  ------------------  --------------------------------
//  req_*       in         req_valid/ready     action, byte count, offset, null
//  rsp_*       out        rsp_valid/ready     granted offset, status, usage
//  csr_*       in         csr_wen (no stall)  pool size in bytes
//
//  One item per cycle sustained while rsp_ready holds; an accepted item passes
//  through the input register, then the result register, which drives rsp.
//  The block stack keeps its top entry in flops and the rest in lpa_ram; the
//  RAM is always reading the entry just below the next top, and a push that
//  writes that same entry is bypassed from a holding register.
//  A stalled rsp holds the result register; req_ready drops only when both
//  the input and result registers are full and rsp_ready is low.
//  Reset empties the pool with size zero; a csr write empties the pool and
//  loads the new size (values above the address space saturate).
//
module lifo_pool_allocator_unit
   import lpa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int ADDR_BITS  = DEF_ADDR_BITS,
   localparam int SizeW     = ADDR_BITS + 1,
   localparam int CntW      = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [SizeW-1:0]     req_request_bytes,
   input  logic [ADDR_BITS-1:0] req_block_offset,
   input  logic                 req_no_block,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_BITS-1:0] rsp_granted_offset,
   output logic [1:0]           rsp_status,
   output logic [SizeW-1:0]     rsp_bytes_in_use,
   output logic [CntW-1:0]      rsp_blocks_live,
   // configuration
   input  logic                 csr_wen,
   input  logic [SizeW-1:0]     csr_wdata
);

   localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int RndW  = ADDR_BITS + 2;
   localparam int EntW  = ADDR_BITS + SizeW;
   localparam logic [SizeW-1:0] POOL_LIMIT = {1'b1, {ADDR_BITS{1'b0}}};
   localparam logic [RndW-1:0]  ALIGN_M1   = RndW'(ALIGN_BYTES - 1);

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic                 s1_action_ff;
   logic [SizeW-1:0]     s1_req_ff;
   logic [ADDR_BITS-1:0] s1_off_ff;
   logic                 s1_null_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_granted_ff;
   status_type           rsp_status_ff;
   logic [SizeW-1:0]     rsp_used_ff;
   logic [CntW-1:0]      rsp_count_ff;

   // Allocator state
   logic [SizeW-1:0]     used_ff,  used_in;    // equals the free offset
   logic [SizeW-1:0]     free_ff,  free_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [ADDR_BITS-1:0] top_off_ff, top_off_in;
   logic [SizeW-1:0]     top_size_ff, top_size_in;
   logic                 byp_ff, byp_in;       // entry below top sits in byp_data_ff
   logic [EntW-1:0]      byp_data_ff;

   // Working signals
   logic                 advance;
   logic                 step;
   logic [RndW-1:0]      rounded;
   logic [SizeW-1:0]     rounded_sz;
   logic                 fits;
   logic                 full;
   logic                 do_push;
   logic                 do_pop;
   status_type           status_in;
   logic [ADDR_BITS-1:0] granted_in;
   logic [EntW-1:0]      below;
   logic [EntW-1:0]      ram_rd_data;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [AW-1:0]        ram_rd_addr;
   logic [CntW-1:0]      count_m1;
   logic [CntW-1:0]      count_in_m2;
   logic [SizeW-1:0]     pool_sat;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   // Round the request up to the granule; one extra bit absorbs the carry.
   assign rounded    = ({1'b0, s1_req_ff} + ALIGN_M1) & ~ALIGN_M1;
   assign rounded_sz = rounded[SizeW-1:0];
   assign fits       = rounded <= {1'b0, free_ff};
   assign full       = count_ff == CntW'(MAX_BLOCKS);

   assign below    = byp_ff ? byp_data_ff : ram_rd_data;
   assign count_m1 = count_ff - CntW'(1);
   assign pool_sat = (csr_wdata > POOL_LIMIT) ? POOL_LIMIT : csr_wdata;

   // Decide the item's outcome and the next allocator state.
   always_comb begin
      do_push     = 1'b0;
      do_pop      = 1'b0;
      status_in   = ST_OK;
      granted_in  = '0;
      used_in     = used_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      top_off_in  = top_off_ff;
      top_size_in = top_size_ff;

      if (s1_action_ff == ACT_ALLOC) begin
         if (!fits) begin
            status_in = ST_EXHAUSTED;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            do_push    = 1'b1;
            granted_in = used_ff[ADDR_BITS-1:0];
         end
      end else if (!s1_null_ff) begin
         if (count_ff == '0 || top_off_ff != s1_off_ff) begin
            status_in = ST_ORDER;
         end else begin
            do_pop = 1'b1;
         end
      end

      if (step && do_push) begin
         used_in     = used_ff + rounded_sz;
         free_in     = free_ff - rounded_sz;
         count_in    = count_ff + CntW'(1);
         top_off_in  = used_ff[ADDR_BITS-1:0];
         top_size_in = rounded_sz;
      end else if (step && do_pop) begin
         used_in     = used_ff - top_size_ff;
         free_in     = free_ff + top_size_ff;
         count_in    = count_m1;
         top_off_in  = below[ADDR_BITS-1:0];
         top_size_in = below[EntW-1:ADDR_BITS];
      end
   end

   // Spill the old top into the RAM on a push; keep the RAM reading the
   // entry that will sit just below the next top.
   assign ram_wr_en   = step && do_push && count_ff != '0;
   assign ram_wr_addr = count_m1[AW-1:0];
   assign count_in_m2 = count_in - CntW'(2);
   assign ram_rd_addr = count_in_m2[AW-1:0];
   assign byp_in      = ram_wr_en;

   lpa_ram #(
      .WIDTH (EntW),
      .DEPTH (MAX_BLOCKS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({top_size_ff, top_off_ff}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         byp_ff       <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         // Size write empties the pool; user sends it only while idle, not enforced.
         if (csr_wen) begin
            used_ff  <= '0;
            free_ff  <= pool_sat;
            count_ff <= '0;
            byp_ff   <= 1'b0;
         end else begin
            used_ff  <= used_in;
            free_ff  <= free_in;
            count_ff <= count_in;
            byp_ff   <= byp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_action_ff <= req_action;
         s1_req_ff    <= req_request_bytes;
         s1_off_ff    <= req_block_offset;
         s1_null_ff   <= req_no_block;
      end
      if (step) begin
         rsp_granted_ff <= granted_in;
         rsp_status_ff  <= status_in;
         rsp_used_ff    <= used_in;
         rsp_count_ff   <= count_in;
      end
      top_off_ff  <= top_off_in;
      top_size_ff <= top_size_in;
      if (byp_in) begin
         byp_data_ff <= {top_size_ff, top_off_ff};
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_offset = rsp_granted_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_bytes_in_use   = rsp_used_ff;
   assign rsp_blocks_live    = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_BLOCKS))
      else $error("block count above stack depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !csr_wen |=> (count_ff == $past(count_ff) ||
                    count_ff == $past(count_ff) + CntW'(1) ||
                    count_ff == $past(count_ff) - CntW'(1)))
      else $error("block count moved by more than one");

   a_bypass_depth: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> count_ff >= CntW'(2))
      else $error("bypass entry live without an entry below top");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_granted_ff == '0)
      else $error("failed item carries a granted offset");

   a_empty_no_use: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> used_ff == '0)
      else $error("bytes in use with no live blocks");

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lifo_pool_allocator_unit. A planned sequence walks
// the empty pool, the pool at full address span, the end-of-pool offset,
// rounding against the free space, out-of-order frees and a full block
// stack. Random phases follow under several pool sizes. Every accepted
// request is run through a local allocator model. Every response is compared
// field by field, in order, with that model's answer or a pinned one.
// ----------------------------------------------------------------------------
module testbench;
   import lpa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int AddrW       = DEF_ADDR_BITS;
   localparam int SizeW       = AddrW + 1;
   localparam int CntW        = $clog2(DEF_MAX_BLOCKS + 1);
   localparam int StackAW     = $clog2(DEF_MAX_BLOCKS);
   localparam int PoolCap     = 1 << AddrW;
   localparam int CycleLimit  = 200000;
   localparam int SettleTicks = 4;    // input and result registers, plus margin
   localparam int SqueezeLen  = 300;
   localparam int NumPhases   = 6;

   // One request as it travels on req_*
   typedef struct packed {
      logic             action;
      logic [SizeW-1:0] bytes;
      logic [AddrW-1:0] offset;
      logic             no_block;
   } alloc_req_type;

   // One response as it shows on rsp_*
   typedef struct packed {
      logic [AddrW-1:0] granted;
      status_type       status;
      logic [SizeW-1:0] in_use;
      logic [CntW-1:0]  live;
   } alloc_rsp_type;

   typedef enum bit { ROW_ITEM, ROW_POOL } row_kind_type;

   // Planned row: either a pool size write (value is the size) or a request
   // repeated reps times (value is the byte count). Pinned rows carry the
   // response typed in by hand; the rest take the model's answer.
   typedef struct packed {
      row_kind_type     kind;
      logic [SizeW-1:0] value;
      logic [6:0]       reps;
      logic             action;
      logic [AddrW-1:0] offset;
      logic             no_block;
      logic             pinned;
      logic [AddrW-1:0] granted;
      status_type       status;
      logic [SizeW-1:0] in_use;
      logic [CntW-1:0]  live;
   } plan_row_type;

   localparam int PlanRows = 24;
   localparam plan_row_type PLAN [PlanRows] = '{
      // Pool size is zero out of reset: only a zero-byte block fits
      '{ROW_ITEM, 17'h00000,  1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_OK,        17'h0, 7'd1},
      '{ROW_ITEM, 17'h00001,  1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_EXHAUSTED, 17'h0, 7'd1},
      // Null free is a no-op; then a wrong offset, the right one, an empty stack
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'hFFFF, 1'b1, 1'b1, 16'h0, ST_OK,        17'h0, 7'd1},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'hFFFF, 1'b0, 1'b1, 16'h0, ST_ORDER,     17'h0, 7'd1},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'h0000, 1'b0, 1'b1, 16'h0, ST_OK,        17'h0, 7'd0},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'h0000, 1'b0, 1'b1, 16'h0, ST_ORDER,     17'h0, 7'd0},
      // Largest byte count, with offset and null flag set but ignored
      '{ROW_ITEM, 17'h1FFFF,  1, ACT_ALLOC, 16'hFFFF, 1'b1, 1'b1, 16'h0, ST_EXHAUSTED, 17'h0, 7'd0},
      // Oversized pool write saturates to the full address span
      '{ROW_POOL, 17'h1FFFF,  0, ACT_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0},
      '{ROW_ITEM, 17'h10000,  1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_OK,    17'h10000, 7'd1},
      // Zero-byte block at the very end of the pool wraps its offset to 0
      '{ROW_ITEM, 17'h00000,  1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_OK,    17'h10000, 7'd2},
      '{ROW_ITEM, 17'h00001,  1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_EXHAUSTED,
        17'h10000, 7'd2},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'h0000, 1'b0, 1'b1, 16'h0, ST_OK,    17'h10000, 7'd1},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'h0000, 1'b0, 1'b1, 16'h0, ST_OK,        17'h0, 7'd0},
      // Small unaligned pool: rounding decides whether a request fits
      '{ROW_POOL, 17'd100,    0, ACT_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0},
      '{ROW_ITEM, 17'd1,      1, ACT_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0},
      '{ROW_ITEM, 17'd9,      1, ACT_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0},
      '{ROW_ITEM, 17'd76,     1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_EXHAUSTED, 17'd24, 7'd2},
      '{ROW_ITEM, 17'd72,     1, ACT_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'd8,    1'b0, 1'b1, 16'h0, ST_ORDER,     17'd96, 7'd3},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'd24,   1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0},
      // Fill the block stack with zero-byte blocks, then push once more
      '{ROW_ITEM, 17'h00000, 62, ACT_ALLOC, 16'h0000, 1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0},
      '{ROW_ITEM, 17'h00000,  1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_FULL,      17'd24, 7'd64},
      // Exhaustion wins over a full stack
      '{ROW_ITEM, 17'd200,    1, ACT_ALLOC, 16'h0000, 1'b0, 1'b1, 16'h0, ST_EXHAUSTED, 17'd24, 7'd64},
      '{ROW_ITEM, 17'h00000,  1, ACT_FREE,  16'd24,   1'b0, 1'b0, 16'h0, ST_OK,        17'h0, 7'd0}
   };

   // ------------------------------------------------------------------------
   // Clock, DUT ports, bench-owned control
   // ------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_action = ACT_ALLOC;
   logic [SizeW-1:0] req_request_bytes = '0;
   logic [AddrW-1:0] req_block_offset = '0;
   logic             req_no_block = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [AddrW-1:0] rsp_granted_offset;
   logic [1:0]       rsp_status;
   logic [SizeW-1:0] rsp_bytes_in_use;
   logic [CntW-1:0]  rsp_blocks_live;
   logic             csr_wen = 1'b0;
   logic [SizeW-1:0] csr_wdata = '0;

   logic             calm = 1'b0;        // no idling on either side
   logic             squeeze_go = 1'b0;  // ask the receiver for one long hold-off
   logic             squeeze_done = 1'b0;
   int               hold_left = 0;
   int               cycles = 0;
   int               failures = 0;
   int               results_checked = 0;
   int               items_sent = 0;
   int               pools_loaded = 0;
   int               status_seen [4] = '{0, 0, 0, 0};

   alloc_rsp_type    pending_results [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lifo_pool_allocator_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_request_bytes  (req_request_bytes),
      .req_block_offset   (req_block_offset),
      .req_no_block       (req_no_block),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_status         (rsp_status),
      .rsp_bytes_in_use   (rsp_bytes_in_use),
      .rsp_blocks_live    (rsp_blocks_live),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Allocator model: pool size, free offset, free and used bytes, block stack
   // ------------------------------------------------------------------------
   logic [SizeW-1:0] pool_size;
   logic [SizeW-1:0] next_offset;
   logic [SizeW-1:0] room;
   logic [SizeW-1:0] in_use;
   logic [CntW-1:0]  depth;
   logic [AddrW-1:0] stack_offset [DEF_MAX_BLOCKS];
   logic [SizeW-1:0] stack_size [DEF_MAX_BLOCKS];

   // Load a new pool size and drop every block
   function automatic void empty_pool(logic [SizeW-1:0] size);
      pool_size   = (size > PoolCap) ? SizeW'(PoolCap) : size;
      next_offset = '0;
      room        = pool_size;
      in_use      = '0;
      depth       = '0;
   endfunction

   // Apply one request to the model and return the response it causes
   function automatic alloc_rsp_type pool_step(alloc_req_type it);
      alloc_rsp_type r;
      logic [17:0]   rounded;
      logic [CntW-1:0] top_idx;
      r = '0;
      r.status = ST_OK;
      top_idx  = depth - 1'b1;
      if (it.action == ACT_ALLOC) begin
         rounded = 18'((({1'b0, it.bytes} + 18'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES);
         if (rounded > {1'b0, room}) begin
            r.status = ST_EXHAUSTED;
         end else if (depth >= DEF_MAX_BLOCKS) begin
            r.status = ST_FULL;
         end else begin
            r.granted                          = next_offset[AddrW-1:0];
            stack_offset[depth[StackAW-1:0]]   = next_offset[AddrW-1:0];
            stack_size[depth[StackAW-1:0]]     = rounded[SizeW-1:0];
            depth                              = depth + 1'b1;
            next_offset                        = next_offset + rounded[SizeW-1:0];
            room                               = room - rounded[SizeW-1:0];
            in_use                             = in_use + rounded[SizeW-1:0];
         end
      end else if (!it.no_block) begin
         if (depth == 0 || stack_offset[top_idx[StackAW-1:0]] != it.offset) begin
            r.status = ST_ORDER;
         end else begin
            depth       = top_idx;
            next_offset = next_offset - stack_size[depth[StackAW-1:0]];
            room        = room + stack_size[depth[StackAW-1:0]];
            in_use      = in_use - stack_size[depth[StackAW-1:0]];
         end
      end
      r.in_use = in_use;
      r.live   = depth;
      status_seen[int'(r.status)]++;
      return r;
   endfunction

   // Random request shaped by the model state: mostly allocations that fit and
   // frees of the top block, the rest noise (bad offsets, null frees, huge sizes)
   function automatic alloc_req_type next_request(int alloc_share);
      alloc_req_type   it;
      int              pick;
      int              sz;
      logic [CntW-1:0] top_idx;
      pick    = $urandom_range(99);
      sz      = $urandom_range(99);
      top_idx = depth - 1'b1;
      it.action   = ACT_ALLOC;
      it.bytes    = '0;
      it.offset   = AddrW'($urandom);
      it.no_block = 1'($urandom_range(1));
      if (pick < alloc_share) begin
         if (sz < 70)
            it.bytes = SizeW'($urandom_range(48));
         else if (sz < 90)
            it.bytes = SizeW'($urandom_range(int'(room)));
         else
            it.bytes = SizeW'(int'(room) + $urandom_range(1, 16));
      end else if (pick < alloc_share + 30) begin
         it.action   = ACT_FREE;
         it.no_block = 1'b0;
         if (depth != 0)
            it.offset = stack_offset[top_idx[StackAW-1:0]];
      end else if (pick < alloc_share + 40) begin
         it.action   = ACT_FREE;
         it.no_block = 1'b1;
      end else if (pick < alloc_share + 50) begin
         it.action   = ACT_FREE;
         it.no_block = 1'b0;
      end else begin
         it.bytes = SizeW'($urandom_range(32'h1FFFF));
      end
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side: drive one request and hold it until accepted, then log
   // the model's response (or the pinned one) as expected
   // ------------------------------------------------------------------------
   task automatic offer(alloc_req_type it, logic pinned, alloc_rsp_type pinned_rsp);
      alloc_rsp_type got;
      req_valid         <= 1'b1;
      req_action        <= it.action;
      req_request_bytes <= it.bytes;
      req_block_offset  <= it.offset;
      req_no_block      <= it.no_block;
      do @(posedge clock); while (!req_ready);
      got = pool_step(it);
      pending_results.push_back(pinned ? pinned_rsp : got);
      items_sent++;
   endtask

   // Drop valid for a cycle now and then, except in the calm stretch
   task automatic maybe_pause();
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop sending, wait for every outstanding response, then let the
   // pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   // Pool size write, only on an idle block; the model follows at the same edge
   task automatic load_pool(logic [SizeW-1:0] size);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_wen <= 1'b0;
      empty_pool(size);
      pools_loaded++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: reset, planned rows, then random phases under new pool sizes
   // ------------------------------------------------------------------------
   initial begin
      plan_row_type  row;
      alloc_req_type it;
      alloc_rsp_type want;
      alloc_rsp_type blank;
      int            phase;
      int            sent;
      int            quota;
      logic [SizeW-1:0] size;

      blank = '0;
      empty_pool('0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PlanRows; i++) begin
         row = PLAN[i];
         if (row.kind == ROW_POOL) begin
            load_pool(row.value);
         end else begin
            it   = '{action: row.action, bytes: row.value, offset: row.offset,
                     no_block: row.no_block};
            want = '{granted: row.granted, status: row.status, in_use: row.in_use,
                     live: row.live};
            repeat (row.reps) begin
               offer(it, row.pinned, want);
               maybe_pause();
            end
         end
      end

      // Phase 0 favours allocations in a full-span pool, phase 1 squeezes the
      // receiver, phase 2 runs on a zero-size pool, phase 3 has no idling
      for (phase = 0; phase < NumPhases; phase++) begin
         case (phase)
            0:       size = SizeW'(PoolCap);
            1:       size = SizeW'($urandom_range(64, 1024));
            2:       size = '0;
            3:       size = SizeW'($urandom_range(32'h1FFFF));
            4:       size = SizeW'(PoolCap - 1);
            default: size = SizeW'($urandom_range(8, 512));
         endcase
         load_pool(size);
         calm <= (phase == 3);
         if (phase == 1)
            squeeze_go <= 1'b1;
         quota = (phase == 2) ? 40 : 70;
         sent  = 0;
         while (sent < quota) begin
            it = next_request((phase == 0) ? 60 : 45);
            offer(it, 1'b0, blank);
            // null frees change nothing and do not count
            if (!(it.action == ACT_FREE && it.no_block))
               sent++;
            maybe_pause();
         end
      end

      drain();
      $display("Covered %0d requests under %0d pool sizes, with planned edge cases and a %0d-cycle",
               items_sent, pools_loaded, SqueezeLen);
      $display("response stall; %0d responses checked, ok/exhausted/order/full = %0d/%0d/%0d/%0d",
               results_checked, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver side: random stalls, one long hold-off, none while calm
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (squeeze_go && !squeeze_done) begin
         squeeze_done <= 1'b1;
         hold_left    <= SqueezeLen;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   // ------------------------------------------------------------------------
   // Response check: every accepted response against the oldest expectation
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_responses
      alloc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response with nothing outstanding: status %0d, live %0d",
                   rsp_status, rsp_blocks_live);
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("granted_offset", 32'(want.granted), 32'(rsp_granted_offset));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("bytes_in_use", 32'(want.in_use), 32'(rsp_bytes_in_use));
            check_field("blocks_live", 32'(want.live), 32'(rsp_blocks_live));
            results_checked++;
         end
      end
   end

   // Hard stop if the run hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycles, pending_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
